// ----- hw/rtl/dcl_pkg.sv -----
// Shared constants, request codes and payload types for the direct-mapped cache lookup.
package dcl_pkg;

    // Field widths of the request and response beats.
    localparam int ADDR_BITS = 16;
    localparam int WORD_BITS = 32;

    // Default geometry; each value must be a power of two.
    localparam int DEF_NUM_LINES      = 64;
    localparam int DEF_WORDS_PER_LINE = 4;
    localparam int DEF_LINE_BYTES     = 16;

    // Request codes; the fourth code is ignored.
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FILL  = 2'd2
    } t_req_kind;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [ADDR_BITS-1:0] address;
        logic [WORD_BITS-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [WORD_BITS-1:0] read_data;
        logic                 write_through;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;   // write zero to the next word during the clearing pass
        logic load;    // capture request and start array reads
        logic commit;  // update arrays and load the response register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last word
    } t_dp_sts;

endpackage

// ----- hw/rtl/dcl_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface dcl_req_if
    import dcl_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dcl_rsp_if
    import dcl_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dcl_ctrl.sv -----
// Controller state machine: clearing pass, request sequencing and response valid.
module dcl_ctrl
    import dcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;
    logic   w_accept;

    // Commit once the response register is free or being drained.
    assign w_commit = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    assign w_accept = (r_state == S_IDLE) && i_in_valid;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.load   = w_accept;
    assign o_cmd.commit = w_commit;

    // Next state and response valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/dcl_dpath.sv -----
// Datapath: address split, tag/word memories, valid/dirty bits and response register.
module dcl_dpath
    import dcl_pkg::*;
#(
    parameter int NUM_LINES      = DEF_NUM_LINES,
    parameter int WORDS_PER_LINE = DEF_WORDS_PER_LINE,
    parameter int LINE_BYTES     = DEF_LINE_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  t_req    i_req,
    output t_rsp    o_rsp
);

    localparam int DEPTH    = NUM_LINES * WORDS_PER_LINE;
    localparam int IDX_W    = $clog2(NUM_LINES);
    localparam int WBITS    = $clog2(WORDS_PER_LINE);
    localparam int SLOT_W   = $clog2(DEPTH);
    localparam int WOFF_LSB = $clog2(WORD_BITS / 8);
    localparam int LINE_LSB = $clog2(LINE_BYTES);
    localparam int TAG_LSB  = LINE_LSB + IDX_W;
    localparam int TAG_W    = (ADDR_BITS > TAG_LSB) ? (ADDR_BITS - TAG_LSB) : 1;

    // Address split of the incoming beat
    logic [ADDR_BITS-1:0] w_word_sh;
    logic [ADDR_BITS-1:0] w_line_sh;
    logic [ADDR_BITS-1:0] w_tag_sh;
    logic [IDX_W-1:0]     w_line;
    logic [SLOT_W-1:0]    w_slot;
    logic [TAG_W-1:0]     w_tag;

    assign w_word_sh = (i_req.address >> WOFF_LSB) & ADDR_BITS'(WORDS_PER_LINE - 1);
    assign w_line_sh = (i_req.address >> LINE_LSB) & ADDR_BITS'(NUM_LINES - 1);
    assign w_tag_sh  = i_req.address >> TAG_LSB;
    assign w_line    = w_line_sh[IDX_W-1:0];
    assign w_slot    = SLOT_W'((w_line_sh << WBITS) | w_word_sh);
    assign w_tag     = w_tag_sh[TAG_W-1:0];

    // Captured request
    logic [1:0]           r_kind;
    logic [IDX_W-1:0]     r_line;
    logic [SLOT_W-1:0]    r_slot;
    logic [TAG_W-1:0]     r_tag;
    logic [WORD_BITS-1:0] r_wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_req.req_type;
            r_line  <= w_line;
            r_slot  <= w_slot;
            r_tag   <= w_tag;
            r_wdata <= i_req.write_data;
        end
    end

    // Per-line valid and dirty bits
    logic [NUM_LINES-1:0] r_valid;
    logic [NUM_LINES-1:0] r_dirty;
    logic [TAG_W-1:0]     r_tag_q;
    logic [WORD_BITS-1:0] r_word_q;
    logic                 w_hit;
    logic                 w_wr_hit;
    logic                 w_fill;

    assign w_hit    = r_valid[r_line] && (r_tag_q == r_tag);
    assign w_wr_hit = i_cmd.commit && (r_kind == REQ_WRITE) && w_hit;
    assign w_fill   = i_cmd.commit && (r_kind == REQ_FILL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (w_fill) begin
            r_valid[r_line] <= 1'b1;
            r_dirty[r_line] <= 1'b0;
        end else if (w_wr_hit) begin
            r_dirty[r_line] <= 1'b1;
        end
    end

    // Tag memory; contents only matter once the line is valid
    logic [TAG_W-1:0] mem_tags [NUM_LINES];

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            mem_tags[r_line] <= r_tag;
        end
        if (i_cmd.load) begin
            r_tag_q <= mem_tags[w_line];
        end
    end

    // Word memory; one write port shared by the clearing pass and write hits
    logic [WORD_BITS-1:0] mem_words [DEPTH];
    logic [SLOT_W-1:0]    r_clr_addr;
    logic                 w_mem_we;
    logic [SLOT_W-1:0]    w_mem_addr;
    logic [WORD_BITS-1:0] w_mem_data;

    assign w_mem_we   = i_cmd.clear || w_wr_hit;
    assign w_mem_addr = i_cmd.clear ? r_clr_addr : r_slot;
    assign w_mem_data = i_cmd.clear ? '0 : r_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_words[w_mem_addr] <= w_mem_data;
        end
        if (i_cmd.load) begin
            r_word_q <= mem_words[w_slot];
        end
    end

    // Clearing pass address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_addr == SLOT_W'(DEPTH - 1));

    // Response register
    t_rsp w_rsp;
    t_rsp r_rsp;

    always_comb begin
        w_rsp.hit           = w_hit;
        w_rsp.read_data     = '0;
        w_rsp.write_through = 1'b0;
        case (r_kind)
            REQ_READ: begin
                if (w_hit) begin
                    w_rsp.read_data = r_word_q;
                end
            end
            REQ_WRITE: begin
                w_rsp.write_through = w_hit;
            end
            default: begin
                w_rsp.read_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- hw/rtl/direct_mapped_cache_lookup.sv -----
// Top level of the direct-mapped write-through cache lookup.
//
// Usage:
//   i_req carries request beats (req_type, address, write_data): read, write or fill.
//   o_rsp carries one response beat per request (hit, read_data, write_through).
//   A beat moves at a rising edge with valid and ready both high.
// Sequencing:
//   The request edge reads the tag and word memories into registers and enters
//   the read state; the commit state then compares and commits once the
//   response register is free.
//   One request is in flight at a time: a new request is taken only after the
//   last one commits, since the controller returns to idle only at the commit.
// Reset:
//   i_rst_n clears valid and dirty bits, then a clearing pass writes zero to all
//   NUM_LINES * WORDS_PER_LINE words (256 by default) of the word memory, one
//   word a cycle; i_req.ready stays low until it ends.
// Stall:
//   The response sits in a register until taken; a new request is still accepted,
//   and its commit waits until the response register is free.
module direct_mapped_cache_lookup
    import dcl_pkg::*;
#(
    parameter int NUM_LINES      = DEF_NUM_LINES,
    parameter int WORDS_PER_LINE = DEF_WORDS_PER_LINE,
    parameter int LINE_BYTES     = DEF_LINE_BYTES
) (
    input logic       i_clk,
    input logic       i_rst_n,
    dcl_req_if.sink   i_req,
    dcl_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    dcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    dcl_dpath #(
        .NUM_LINES      (NUM_LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .LINE_BYTES     (LINE_BYTES)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req.data),
        .o_rsp   (o_rsp.data)
    );

`ifndef SYNTHESIS
    // A write-through is only signaled on a hit
    a_wthru_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.write_through) |-> o_rsp.data.hit)
        else $error("write_through without hit");

    // Nonzero read data only comes from a hit
    a_rdata_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.data.read_data != '0)) |-> o_rsp.data.hit)
        else $error("read data on a miss");

    // Only one request in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while busy");

    // A fresh response must follow an accepted request
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(i_req.valid && i_req.ready, 3))
        else $error("response without matching request");
`endif

endmodule
